// ===== rtl/smsd_pkg.sv =====
// Shared types and constants for the sample mean and deviation engine.
`timescale 1ns / 1ps
package smsd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int REP_W      = 9;
  localparam int SUM_W      = 32;
  localparam int OUT_W      = 28;
  localparam int SQSUM_W    = 64;
  localparam int PROD_W     = 2 * OUT_W;
  localparam int DIV_W      = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int ROOT_W     = DIV_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int ROOT_REM_W = ROOT_W + 2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_REP = 2'd1,
    ST_ONE_REP  = 2'd2,
    ST_DROPPED  = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_LOAD    = 10'b0000000001,
    S_MDIV_GO = 10'b0000000010,
    S_MDIV_WT = 10'b0000000100,
    S_SQ_GO   = 10'b0000001000,
    S_SQ_WT   = 10'b0000010000,
    S_VDIV_GO = 10'b0000100000,
    S_VDIV_WT = 10'b0001000000,
    S_SQRT_GO = 10'b0010000000,
    S_SQRT_WT = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_var;
    logic mean_cap;
    logic sq_start;
    logic sqrt_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic rep_zero;
    logic rep_one;
    logic div_done;
    logic sq_done;
    logic sqrt_done;
  } dp_sts_t;

endpackage

// ===== rtl/smsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smsd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps
module smsd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smsd_pkg::DIV_W-1:0] dividend_i,
  input  logic [smsd_pkg::REP_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [smsd_pkg::DIV_W-1:0] quotient_o
);
  import smsd_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     acc_q, acc_d;
  logic [REP_W-1:0]     rem_q, rem_d;
  logic [REP_W-1:0]     dvs_q, dvs_d;
  logic [REP_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, acc_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? REP_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[REP_W-1:0];
      acc_d = {acc_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

// ===== rtl/smsd_dp.sv =====
// Datapath: sample store, running sum, squared-deviation pass, divider, square root.
`timescale 1ns / 1ps
module smsd_dp #(
  parameter int MAX_SAMPLES   = 256,
  parameter int FRACTION_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smsd_pkg::dp_cmd_t             cmd_i,
  output smsd_pkg::dp_sts_t             sts_o,
  input  logic [smsd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          cfg_we_i,
  input  logic [smsd_pkg::REP_W-1:0]    repetition_count_i,
  output logic                          result_valid_o,
  output logic [smsd_pkg::OUT_W-1:0]    mean_q4_o,
  output logic [smsd_pkg::OUT_W-1:0]    deviation_q4_o,
  output logic [1:0]                    status_o
);
  import smsd_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // set accumulation
  logic [REP_W-1:0] rep_q;
  logic [CW-1:0]    fill_q;
  logic [SUM_W-1:0] sum_q;
  logic             ovf_q;
  logic             full;

  assign full = fill_q == CW'(MAX_SAMPLES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q  <= REP_W'(1);
      fill_q <= '0;
      sum_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rep_q <= repetition_count_i;
      end
      if (cmd_i.emit) begin
        fill_q <= '0;
        sum_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          fill_q <= fill_q + 1'b1;
          sum_q  <= sum_q + SUM_W'(sample_i);
        end
      end
    end
  end

  // sample store
  logic [CW-1:0]       rd_ptr_q;
  logic                sq_run_q;
  logic                issue;
  logic [SAMPLE_W-1:0] rdata;

  assign issue = sq_run_q && (rd_ptr_q != fill_q);

  smsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (sample_i),
    .re_i    (issue),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // divider, shared by mean and variance
  logic [DIV_W-1:0] div_dividend;
  logic [REP_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quot;
  logic             div_done;
  logic [SQSUM_W-1:0] sqsum_q;

  assign div_dividend = cmd_i.div_sel_var ? DIV_W'(sqsum_q)
                                          : (DIV_W'(sum_q) << FRACTION_BITS);
  assign div_divisor  = cmd_i.div_sel_var ? rep_q - 1'b1 : rep_q;

  smsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  logic [OUT_W-1:0] mean_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_cap) begin
      mean_q <= (div_quot > DIV_W'(OUT_MAX)) ? OUT_MAX : div_quot[OUT_W-1:0];
    end
  end

  // squared deviation pass: read, difference, square, accumulate
  logic              v1_q, v2_q, v3_q;
  logic              sq_done_q;
  logic [OUT_W-1:0]  s_val;
  logic [OUT_W-1:0]  d_q;
  logic [PROD_W-1:0] prod_q;

  assign s_val = OUT_W'(rdata) << FRACTION_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_run_q  <= 1'b0;
      rd_ptr_q  <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      sq_done_q <= 1'b0;
    end else begin
      v1_q      <= issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      sq_done_q <= 1'b0;
      if (cmd_i.sq_start) begin
        sq_run_q <= 1'b1;
        rd_ptr_q <= '0;
      end else if (sq_run_q) begin
        if (issue) begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          sq_run_q  <= 1'b0;
          sq_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= (s_val >= mean_q) ? s_val - mean_q : mean_q - s_val;
    prod_q <= PROD_W'(d_q) * PROD_W'(d_q);
    if (cmd_i.sq_start) begin
      sqsum_q <= '0;
    end else if (v3_q) begin
      sqsum_q <= sqsum_q + SQSUM_W'(prod_q);
    end
  end

  // square root, one result bit per cycle
  logic                  rt_busy_q;
  logic                  rt_done_q;
  logic [ROOT_CNT_W-1:0] rt_cnt_q;
  logic [DIV_W-1:0]      rad_q;
  logic [ROOT_REM_W-1:0] rrem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [ROOT_REM_W+1:0] rrem_sh;
  logic [ROOT_REM_W+1:0] trial;
  logic                  rt_ge;

  assign rrem_sh = {rrem_q, rad_q[DIV_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rt_ge   = rrem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_busy_q <= 1'b0;
      rt_done_q <= 1'b0;
      rt_cnt_q  <= '0;
    end else begin
      rt_done_q <= 1'b0;
      if (cmd_i.sqrt_start) begin
        rt_busy_q <= 1'b1;
        rt_cnt_q  <= '0;
      end else if (rt_busy_q) begin
        rt_cnt_q <= rt_cnt_q + 1'b1;
        if (rt_cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
          rt_busy_q <= 1'b0;
          rt_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= div_quot;
      rrem_q <= '0;
      root_q <= '0;
    end else if (rt_busy_q) begin
      rad_q  <= rad_q << 2;
      rrem_q <= rt_ge ? ROOT_REM_W'(rrem_sh - trial) : rrem_sh[ROOT_REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], rt_ge};
    end
  end

  // result word
  logic       rep_zero, rep_one;
  logic       res_valid_q;
  logic [OUT_W-1:0] res_mean_q, res_dev_q;
  status_e    res_status_q, status_d;

  assign rep_zero = rep_q == '0;
  assign rep_one  = rep_q == REP_W'(1);

  always_comb begin
    if (rep_zero) begin
      status_d = ST_ZERO_REP;
    end else if (rep_one) begin
      status_d = ST_ONE_REP;
    end else if (ovf_q) begin
      status_d = ST_DROPPED;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_mean_q   <= rep_zero ? '0 : mean_q;
      res_dev_q    <= (rep_zero || rep_one) ? '0 :
                      (root_q > ROOT_W'(OUT_MAX)) ? OUT_MAX : root_q[OUT_W-1:0];
      res_status_q <= status_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign mean_q4_o      = res_mean_q;
  assign deviation_q4_o = res_dev_q;
  assign status_o       = res_status_q;

  assign sts_o.rep_zero  = rep_zero;
  assign sts_o.rep_one   = rep_one;
  assign sts_o.div_done  = div_done;
  assign sts_o.sq_done   = sq_done_q;
  assign sts_o.sqrt_done = rt_done_q;

endmodule

// ===== rtl/smsd_ctrl.sv =====
// Controller: sequences load, mean division, deviation pass, division and root.
`timescale 1ns / 1ps
module smsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  output logic              busy_o,
  output smsd_pkg::dp_cmd_t cmd_o,
  input  smsd_pkg::dp_sts_t sts_i
);
  import smsd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == S_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && last_i) begin
          state_d = sts_i.rep_zero ? S_OUT : S_MDIV_GO;
        end
      end
      S_MDIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MDIV_WT;
      end
      S_MDIV_WT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_cap = 1'b1;
          state_d        = sts_i.rep_one ? S_OUT : S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd_o.sq_start = 1'b1;
        state_d        = S_SQ_WT;
      end
      S_SQ_WT: begin
        if (sts_i.sq_done) begin
          state_d = S_VDIV_GO;
        end
      end
      S_VDIV_GO: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_var = 1'b1;
        state_d           = S_VDIV_WT;
      end
      S_VDIV_WT: begin
        if (sts_i.div_done) begin
          state_d = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_WT;
      end
      S_SQRT_WT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_LOAD;

endmodule

// ===== rtl/sample_mean_stddev_engine.sv =====
// Top level of the sample mean and Bessel-corrected standard deviation engine.
//
// Input: a word (sample_i, last_i) is taken at a clock edge with start_i high
// and busy_o low. While busy_o is low, samples load one per cycle into the
// sample store; samples beyond MAX_SAMPLES are dropped and reported by
// status unless the count is zero or one. On a word with last_i set, busy_o
// rises and the engine computes: the mean division in the shared radix-2
// divider (64 quotient bits), the deviation pass through the store read port
// and the squaring stage, the variance division in the same divider, the
// bit-serial square root and the result register, for a repetition count of
// two or more. A count of one skips the pass, division and root; a count of
// zero goes straight to the result register.
// Output: result_valid_o is high for exactly one cycle with mean_q4_o,
// deviation_q4_o and status_o; the receiver cannot stall. The next set may
// start in the strobe cycle.
// Configuration: cfg_we_i writes repetition_count_i; the user must do so only
// while idle, as the block does not enforce it.
// Reset: asynchronous, active low; clears the set, count register to one.
`timescale 1ns / 1ps
module sample_mean_stddev_engine #(
  parameter int MAX_SAMPLES   = 256,
  parameter int FRACTION_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [smsd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic [smsd_pkg::REP_W-1:0]    repetition_count_i,
  output logic                          result_valid_o,
  output logic [smsd_pkg::OUT_W-1:0]    mean_q4_o,
  output logic [smsd_pkg::OUT_W-1:0]    deviation_q4_o,
  output logic [1:0]                    status_o
);
  import smsd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  smsd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .last_i  (last_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  smsd_dp #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sample_i           (sample_i),
    .cfg_we_i           (cfg_we_i),
    .repetition_count_i (repetition_count_i),
    .result_valid_o     (result_valid_o),
    .mean_q4_o          (mean_q4_o),
    .deviation_q4_o     (deviation_q4_o),
    .status_o           (status_o)
  );

  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_i |=> busy_o)
    else $error("engine did not go busy after last word");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_emit_to_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> result_valid_o && !busy_o)
    else $error("emit not followed by result strobe");

  a_zero_rep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_ZERO_REP |-> mean_q4_o == '0 && deviation_q4_o == '0)
    else $error("zero repetitions must give zero mean and deviation");

  a_one_rep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_ONE_REP |-> deviation_q4_o == '0)
    else $error("one repetition must give zero deviation");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sample mean and standard deviation engine.
`timescale 1ns / 1ps
module testbench;
  import smsd_pkg::*;

  localparam int FRAC_BITS   = 4;
  localparam int STORE_DEPTH = 256;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [OUT_W-1:0] mean_q4;
    logic [OUT_W-1:0] deviation_q4;
    status_e          status;
  } stats_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [SAMPLE_W-1:0] sample_i;
  logic                last_i;
  logic                cfg_we_i;
  logic [REP_W-1:0]    repetition_count_i;
  logic                result_valid_o;
  logic [OUT_W-1:0]    mean_q4_o;
  logic [OUT_W-1:0]    deviation_q4_o;
  logic [1:0]          status_o;

  sample_mean_stddev_engine i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .sample_i          (sample_i),
    .last_i            (last_i),
    .cfg_we_i          (cfg_we_i),
    .repetition_count_i(repetition_count_i),
    .result_valid_o    (result_valid_o),
    .mean_q4_o         (mean_q4_o),
    .deviation_q4_o    (deviation_q4_o),
    .status_o          (status_o)
  );

  // model state
  logic [SAMPLE_W-1:0] set_samples [STORE_DEPTH];
  int unsigned         set_fill     = 0;
  logic [SUM_W-1:0]    set_sum      = '0;
  logic                set_dropped  = 1'b0;
  logic [REP_W-1:0]    reps_model   = 9'd1;

  stats_t expected_stats[$];
  int     error_count = 0;
  int     words_sent  = 0;
  int     idle_pct    = 0;
  int     quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] square;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial  = root | (32'd1 << b);
      square = {32'd0, trial} * {32'd0, trial};
      if (square <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_q4(input logic [63:0] v);
    return (v > {36'd0, OUT_MAX}) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  task automatic predict_stats(input logic [SAMPLE_W-1:0] s, input logic lst);
    stats_t      res;
    logic [63:0] scaled;
    logic [63:0] diff;
    logic [63:0] sq_sum;
    if (set_fill < STORE_DEPTH) begin
      set_samples[set_fill] = s;
      set_fill++;
      set_sum = set_sum + {8'd0, s};
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      res.deviation_q4 = '0;
      if (reps_model == 0) begin
        res.mean_q4 = '0;
        res.status  = ST_ZERO_REP;
      end else begin
        res.mean_q4 = clamp_q4(({32'd0, set_sum} << FRAC_BITS) / {55'd0, reps_model});
        if (reps_model == 1) res.status = ST_ONE_REP;
        else if (set_dropped) res.status = ST_DROPPED;
        else res.status = ST_OK;
      end
      if (reps_model >= 2) begin
        sq_sum = '0;
        for (int n = 0; n < set_fill; n++) begin
          scaled = {40'd0, set_samples[n]} << FRAC_BITS;
          diff   = (scaled >= {36'd0, res.mean_q4}) ? scaled - {36'd0, res.mean_q4}
                                                     : {36'd0, res.mean_q4} - scaled;
          sq_sum += diff * diff;
        end
        res.deviation_q4 = clamp_q4({32'd0, floor_root(sq_sum / {55'd0, reps_model - 9'd1})});
      end
      expected_stats = {expected_stats, res};
      set_fill    = 0;
      set_sum     = '0;
      set_dropped = 1'b0;
    end
  endtask

  // result check, word prediction and stall watchdog
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_stats.size() == 0) begin
          $error("result word with nothing expected");
          error_count++;
        end else begin
          want = expected_stats.pop_front();
          if (mean_q4_o !== want.mean_q4) begin
            $error("mean_q4: expected %0d, got %0d", want.mean_q4, mean_q4_o);
            error_count++;
          end
          if (deviation_q4_o !== want.deviation_q4) begin
            $error("deviation_q4: expected %0d, got %0d", want.deviation_q4, deviation_q4_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
        end
      end
      if (cfg_we_i) reps_model = repetition_count_i;
      if (start_i && !busy_o) predict_stats(sample_i, last_i);
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic lst);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    sample_i <= s;
    last_i   <= lst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_stats.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_repetitions(input logic [REP_W-1:0] reps);
    drain_results();
    cfg_we_i           <= 1'b1;
    repetition_count_i <= reps;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_set(input int len, input int style);
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] s;
    base = SAMPLE_W'($urandom);
    for (int n = 0; n < len; n++) begin
      case (style)
        0:       s = SAMPLE_W'($urandom);
        1:       s = base ^ SAMPLE_W'($urandom_range(15, 0));
        2:       s = SAMPLE_W'($urandom_range(255, 0));
        default: s = $urandom_range(1, 0) ? 24'hFFFFFF : 24'h0;
      endcase
      send_word(s, n == len - 1);
    end
  endtask

  // reset count of one: mean is the plain sum, saturating
  task automatic test_one_repetition();
    send_word(24'hFFFFFF, 1'b0);
    send_word(24'hFFFFFF, 1'b1);
    send_word(24'h000000, 1'b1);
    drain_results();
  endtask

  task automatic test_zero_repetitions();
    set_repetitions(9'd0);
    send_word(24'h123456, 1'b0);
    send_word(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_count_extremes();
    set_repetitions(9'd256);
    repeat (2) send_word(24'hFFFFFF, 1'b0);
    send_word(24'hFFFFFF, 1'b1);
    set_repetitions(9'd511);
    send_word(24'hFFFFFF, 1'b0);
    send_word(24'h000000, 1'b1);
    set_repetitions(9'd2);
    send_word(24'h000000, 1'b0);
    send_word(24'hFFFFFF, 1'b1);
    send_word(24'h800000, 1'b1);
    // saturated mean, deviation saturates too
    repeat (3) send_word(24'hFFFFFF, 1'b0);
    repeat (2) send_word(24'h000000, 1'b0);
    send_word(24'h000000, 1'b1);
    set_repetitions(9'd4);
    send_word(24'hAAAAAA, 1'b0);
    send_word(24'h555555, 1'b0);
    send_word(24'h000001, 1'b0);
    send_word(24'h800000, 1'b1);
  endtask

  task automatic test_random_sets();
    int               set_no;
    int               len;
    logic [REP_W-1:0] reps;
    set_no = 0;
    while (words_sent < 1320) begin
      case ((words_sent / 250) % 4)
        1:       idle_pct = 50;
        2:       idle_pct = 24;
        default: idle_pct = 0;
      endcase
      if (set_no % 20 == 5) len = $urandom_range(300, 257);
      else if ($urandom_range(15, 0) == 0) len = $urandom_range(256, 200);
      else len = $urandom_range(12, 1);
      if ($urandom_range(2, 0) == 0) begin
        case ($urandom_range(9, 0))
          0:       reps = 9'd0;
          1:       reps = 9'd1;
          2:       reps = 9'd511;
          3:       reps = 9'd256;
          4, 5, 6: reps = (len < 2) ? 9'd2 : REP_W'(len);
          default: reps = REP_W'($urandom_range(300, 2));
        endcase
        set_repetitions(reps);
      end
      send_set(len, $urandom_range(3, 0));
      set_no++;
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    start_i            <= 1'b0;
    sample_i           <= '0;
    last_i             <= 1'b0;
    cfg_we_i           <= 1'b0;
    repetition_count_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_one_repetition();
    test_zero_repetitions();
    test_count_extremes();
    test_random_sets();

    drain_results();
    repeat (450) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
